// ----- hw/rtl/capdu_pkg.sv -----
package capdu_pkg;

	localparam int unsigned STD_MAX_CHUNK = 255;
	localparam int unsigned EXT_MAX_CHUNK = 32767;
	localparam int unsigned LE_STD_LIMIT  = 256;
	localparam int unsigned LE_EXT_LIMIT  = 32767;

	// room for the longest run of result words caused by one input word (10)
	localparam int unsigned RUN_MAX = 11;
	localparam int unsigned CNT_W   = $clog2(RUN_MAX + 1);
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_CLASS_BYTE       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INSTRUCTION_BYTE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EXTENDED_MODE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_LENGTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_P1_MORE_CODE     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_P1_LAST_CODE     = 3'd5;

	localparam logic [7:0] P1_MORE_RESET = 8'h11;
	localparam logic [7:0] P1_LAST_RESET = 8'h91;

	typedef logic [7:0] byte_t;

	typedef struct packed {
		byte_t       class_byte;
		byte_t       instruction_byte;
		logic        extended_mode;
		logic [15:0] expected_length;
		byte_t       p1_more_code;
		byte_t       p1_last_code;
	} cfg_t;

	typedef struct packed {
		byte_t       fragment_number;
		logic [14:0] chunk_bytes_left;
		logic        in_final_chunk;
		logic        command_open;
	} frag_state_t;

	typedef struct packed {
		logic [RUN_MAX-1:0][7:0] bytes;
		logic [CNT_W-1:0]        count;
		logic                    fragment_end;
		logic                    command_end;
	} run_t;

endpackage

// ----- hw/rtl/command_apdu_fragmenter.sv -----
// Command APDU fragmenter: one payload word in, a run of framed words out. Each input word
// is taken into an input register; from there the framing logic builds its whole run of
// result words (header, Lc, data, Le) combinationally and loads it into a shift register
// that feeds the output, one word per cycle while out_stall is low. A data byte inside an
// open chunk gives one word, two or three when it closes the command and Le follows; a word
// that opens a chunk gives 6 to 10 words and a command without data 4 to 7. The next input
// word is taken while the last word of a run is delivered.
module command_apdu_fragmenter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [capdu_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [capdu_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [7:0]                          payload_byte,
	input  logic [15:0]                         bytes_remaining,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [7:0]                          out_byte,
	output logic                                fragment_end,
	output logic                                command_end,
	output logic                                run_end
);

	localparam logic [capdu_pkg::CNT_W-1:0] ONE = capdu_pkg::CNT_W'(1);

	capdu_pkg::cfg_t        cfg_q;
	capdu_pkg::frag_state_t state_q;
	capdu_pkg::frag_state_t state_next;
	capdu_pkg::run_t        run_new;

	logic        valid_s1;
	logic [7:0]  payload_s1;
	logic [15:0] remaining_s1;

	logic [capdu_pkg::RUN_MAX-1:0][7:0] buf_q;
	logic [capdu_pkg::CNT_W-1:0]        cnt_q;
	logic                               run_valid_q;
	logic                               frag_end_q;
	logic                               cmd_end_q;

	logic take;
	logic last_take;
	logic move;
	logic accept_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{class_byte: 8'h00, instruction_byte: 8'h00, extended_mode: 1'b0,
				expected_length: 16'h0000, p1_more_code: capdu_pkg::P1_MORE_RESET,
				p1_last_code: capdu_pkg::P1_LAST_RESET};
		end else if (cfg_we) begin
			unique case (cfg_index)
				capdu_pkg::CFG_CLASS_BYTE:       cfg_q.class_byte <= cfg_data[7:0];
				capdu_pkg::CFG_INSTRUCTION_BYTE: cfg_q.instruction_byte <= cfg_data[7:0];
				capdu_pkg::CFG_EXTENDED_MODE:    cfg_q.extended_mode <= cfg_data[0];
				capdu_pkg::CFG_EXPECTED_LENGTH:  cfg_q.expected_length <= cfg_data;
				capdu_pkg::CFG_P1_MORE_CODE:     cfg_q.p1_more_code <= cfg_data[7:0];
				capdu_pkg::CFG_P1_LAST_CODE:     cfg_q.p1_last_code <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign take      = run_valid_q && !out_stall;
	assign last_take = take && (cnt_q == ONE);
	assign move      = valid_s1 && (!run_valid_q || last_take);
	assign in_stall  = valid_s1 && !move;
	assign accept_in = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept_in) begin
			valid_s1 <= 1'b1;
		end else if (move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			payload_s1   <= payload_byte;
			remaining_s1 <= bytes_remaining;
		end
	end

	capdu_frame u_frame (
		.cfg             (cfg_q),
		.state           (state_q),
		.payload_byte    (payload_s1),
		.bytes_remaining (remaining_s1),
		.run             (run_new),
		.state_next      (state_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			run_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else if (move) begin
			state_q     <= state_next;
			run_valid_q <= 1'b1;
			cnt_q       <= run_new.count;
		end else if (take) begin
			cnt_q <= cnt_q - ONE;
			if (cnt_q == ONE) begin
				run_valid_q <= 1'b0;
			end
		end
	end

	// output shift register, word 0 is on the port
	always_ff @(posedge clk) begin
		if (move) begin
			buf_q      <= run_new.bytes;
			frag_end_q <= run_new.fragment_end;
			cmd_end_q  <= run_new.command_end;
		end else if (take) begin
			for (int i = 0; i < capdu_pkg::RUN_MAX - 1; i++) begin
				buf_q[i] <= buf_q[i+1];
			end
		end
	end

	assign out_valid    = run_valid_q;
	assign out_byte     = buf_q[0];
	assign run_end      = (cnt_q == ONE);
	assign fragment_end = frag_end_q && run_end;
	assign command_end  = cmd_end_q && run_end;

	a_run_holds: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid_q && !last_take && !move |=> run_valid_q)
		else $error("run dropped before its last word was taken");

	a_cnt_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid_q |-> cnt_q != '0)
		else $error("active run with zero word count");

	a_chunk_open: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.chunk_bytes_left != '0 |-> state_q.command_open)
		else $error("chunk bytes pending outside an open command");

	a_cmd_frag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && command_end |-> fragment_end && run_end)
		else $error("command end without fragment end");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !move |=> valid_s1 && $stable(remaining_s1))
		else $error("input register lost a word");

endmodule

// ----- hw/rtl/capdu_frame.sv -----
module capdu_frame (
	input  capdu_pkg::cfg_t        cfg,
	input  capdu_pkg::frag_state_t state,
	input  capdu_pkg::byte_t       payload_byte,
	input  logic [15:0]            bytes_remaining,
	output capdu_pkg::run_t        run,
	output capdu_pkg::frag_state_t state_next
);

	localparam logic [15:0] STD_MAX = 16'(capdu_pkg::STD_MAX_CHUNK);
	localparam logic [15:0] EXT_MAX = 16'(capdu_pkg::EXT_MAX_CHUNK);
	localparam logic [15:0] LE_STD  = 16'(capdu_pkg::LE_STD_LIMIT);
	localparam logic [15:0] LE_EXT  = 16'(capdu_pkg::LE_EXT_LIMIT);
	localparam logic [capdu_pkg::CNT_W-1:0] ONE = capdu_pkg::CNT_W'(1);

	logic [15:0] le_lim;
	logic [15:0] le_val;
	logic [15:0] chunk_max;
	logic [14:0] chunk_len;
	logic        chunk_last;

	always_comb begin
		le_lim = cfg.extended_mode ? LE_EXT : LE_STD;
		le_val = (cfg.expected_length > le_lim) ? le_lim : cfg.expected_length;
		chunk_max = cfg.extended_mode ? EXT_MAX : STD_MAX;
		chunk_last = bytes_remaining <= chunk_max;
		chunk_len = chunk_last ? bytes_remaining[14:0] : chunk_max[14:0];
	end

	always_comb begin
		logic [capdu_pkg::CNT_W-1:0] n;
		capdu_pkg::frag_state_t      s;
		n = '0;
		s = state;
		run = '0;

		if (bytes_remaining == 16'd0) begin
			// command without data: header, then Le (if nonzero) with a leading zero when extended
			run.bytes[n] = cfg.class_byte;       n = n + ONE;
			run.bytes[n] = cfg.instruction_byte; n = n + ONE;
			run.bytes[n] = cfg.p1_last_code;     n = n + ONE;
			run.bytes[n] = 8'h00;                n = n + ONE;
			if (le_val != 16'd0) begin
				if (cfg.extended_mode) begin
					run.bytes[n] = 8'h00;         n = n + ONE;
					run.bytes[n] = le_val[15:8];  n = n + ONE;
					run.bytes[n] = le_val[7:0];   n = n + ONE;
				end else begin
					run.bytes[n] = le_val[7:0];   n = n + ONE;
				end
			end
			run.fragment_end = 1'b1;
			run.command_end  = 1'b1;
			s.fragment_number  = 8'd1;
			s.chunk_bytes_left = '0;
			s.in_final_chunk   = 1'b0;
			s.command_open     = 1'b0;
		end else begin
			if (s.chunk_bytes_left == 15'd0) begin
				if (!s.command_open) begin
					s.fragment_number = 8'd0;
				end
				run.bytes[n] = cfg.class_byte;       n = n + ONE;
				run.bytes[n] = cfg.instruction_byte; n = n + ONE;
				run.bytes[n] = chunk_last ? cfg.p1_last_code : cfg.p1_more_code;
				n = n + ONE;
				run.bytes[n] = s.fragment_number;    n = n + ONE;
				s.fragment_number = s.fragment_number + 8'd1;
				if (cfg.extended_mode) begin
					run.bytes[n] = 8'h00;                    n = n + ONE;
					run.bytes[n] = {1'b0, chunk_len[14:8]};  n = n + ONE;
					run.bytes[n] = chunk_len[7:0];           n = n + ONE;
				end else begin
					run.bytes[n] = chunk_len[7:0];           n = n + ONE;
				end
				s.chunk_bytes_left = chunk_len;
				s.in_final_chunk   = chunk_last;
				s.command_open     = 1'b1;
			end
			run.bytes[n] = payload_byte; n = n + ONE;
			s.chunk_bytes_left = s.chunk_bytes_left - 15'd1;
			if (s.chunk_bytes_left == 15'd0) begin
				run.fragment_end = 1'b1;
				if (s.in_final_chunk) begin
					if (le_val != 16'd0) begin
						if (cfg.extended_mode) begin
							run.bytes[n] = le_val[15:8]; n = n + ONE;
						end
						run.bytes[n] = le_val[7:0]; n = n + ONE;
					end
					run.command_end   = 1'b1;
					s.fragment_number = 8'd0;
					s.in_final_chunk  = 1'b0;
					s.command_open    = 1'b0;
				end
			end
		end
		run.count  = n;
		state_next = s;
	end

endmodule
